### src/x86mpp_pkg.sv
// package for the 8086 mov/push/pop unit
// opcodes, status and register class codes, decoded item type; no dependencies
package x86mpp_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;

  // opcodes and opcode groups
  localparam logic [7:0] OP_MOV_R8_IMM = 8'hB0;
  localparam logic [7:0] OP_MOV_R16_IMM = 8'hB8;
  localparam logic [7:0] OP_PUSH = 8'h50;
  localparam logic [7:0] OP_POP = 8'h58;
  localparam logic [7:0] OP_MOV_RM8_R8 = 8'h88;
  localparam logic [7:0] OP_MOV_RM16_R16 = 8'h89;
  localparam logic [7:0] OP_MOV_R8_RM8 = 8'h8A;
  localparam logic [7:0] OP_MOV_R16_RM16 = 8'h8B;
  localparam logic [7:0] OP_MOV_RM16_SREG = 8'h8C;
  localparam logic [7:0] OP_MOV_SREG_RM16 = 8'h8E;
  localparam logic [7:0] OP_MOV_RM8_IMM = 8'hC6;
  localparam logic [7:0] OP_MOV_RM16_IMM = 8'hC7;
  localparam logic [7:0] OP_GROUP_MASK = 8'hF8;

  // result status
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_HALTED = 2'd2;

  // register classes
  localparam logic [1:0] RC_GEN16 = 2'd0;
  localparam logic [1:0] RC_GEN8 = 2'd1;
  localparam logic [1:0] RC_SEG = 2'd2;

  // operation kinds after decode
  localparam logic [3:0] K_IMM8 = 4'd0;
  localparam logic [3:0] K_IMM16 = 4'd1;
  localparam logic [3:0] K_PUSH = 4'd2;
  localparam logic [3:0] K_POP = 4'd3;
  localparam logic [3:0] K_88 = 4'd4;
  localparam logic [3:0] K_89 = 4'd5;
  localparam logic [3:0] K_8A = 4'd6;
  localparam logic [3:0] K_8B = 4'd7;
  localparam logic [3:0] K_8C = 4'd8;
  localparam logic [3:0] K_8E = 4'd9;
  localparam logic [3:0] K_C6 = 4'd10;
  localparam logic [3:0] K_C7 = 4'd11;
  localparam logic [3:0] K_BAD = 4'd12;

  // register numbers
  localparam logic [2:0] R_BX = 3'd3;
  localparam logic [2:0] R_SP = 3'd4;
  localparam logic [2:0] R_BP = 3'd5;
  localparam logic [2:0] R_SI = 3'd6;
  localparam logic [2:0] R_DI = 3'd7;
  localparam logic [1:0] S_SS = 2'd2;
  localparam logic [1:0] S_DS = 2'd3;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] opreg;
    logic [1:0] md;
    logic [2:0] rg;
    logic [2:0] rm;
    logic [15:0] disp;
    logic [15:0] imm;
  } dec_t;

  // result item
  typedef struct packed {
    logic [1:0] status;
    logic mem_written;
    logic [19:0] phys_address;
    logic [15:0] mem_value;
    logic mem_wide;
    logic reg_written;
    logic [1:0] reg_class;
    logic [2:0] reg_number;
    logic [15:0] reg_value;
  } res_t;

endpackage

### src/x86mpp_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module x86mpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input logic clk,
  input logic we,
  input logic [$clog2(DEPTH)-1:0] waddr,
  input logic [WIDTH-1:0] wdata,
  input logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/x86mpp_front.sv
// front end: accepts instructions, classifies them, two-entry queue
// depends on x86mpp_pkg
module x86mpp_front (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [7:0] opcode,
  input logic [7:0] modrm,
  input logic [15:0] displacement,
  input logic [15:0] immediate,
  output logic q_valid,
  input logic q_pop,
  output x86mpp_pkg::dec_t q_item
);
  x86mpp_pkg::dec_t d;
  x86mpp_pkg::dec_t slot [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;
  logic push;

  // classify opcode
  always_comb begin
    d.opreg = opcode[2:0];
    d.md = modrm[7:6];
    d.rg = modrm[5:3];
    d.rm = modrm[2:0];
    d.disp = displacement;
    d.imm = immediate;
    if ((opcode & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_MOV_R8_IMM)
      d.kind = x86mpp_pkg::K_IMM8;
    else if ((opcode & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_MOV_R16_IMM)
      d.kind = x86mpp_pkg::K_IMM16;
    else if ((opcode & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_PUSH)
      d.kind = x86mpp_pkg::K_PUSH;
    else if ((opcode & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_POP)
      d.kind = x86mpp_pkg::K_POP;
    else begin
      unique case (opcode)
        x86mpp_pkg::OP_MOV_RM8_R8: d.kind = x86mpp_pkg::K_88;
        x86mpp_pkg::OP_MOV_RM16_R16: d.kind = x86mpp_pkg::K_89;
        x86mpp_pkg::OP_MOV_R8_RM8: d.kind = x86mpp_pkg::K_8A;
        x86mpp_pkg::OP_MOV_R16_RM16: d.kind = x86mpp_pkg::K_8B;
        x86mpp_pkg::OP_MOV_RM16_SREG: d.kind = x86mpp_pkg::K_8C;
        x86mpp_pkg::OP_MOV_SREG_RM16: d.kind = x86mpp_pkg::K_8E;
        x86mpp_pkg::OP_MOV_RM8_IMM: d.kind = x86mpp_pkg::K_C6;
        x86mpp_pkg::OP_MOV_RM16_IMM: d.kind = x86mpp_pkg::K_C7;
        default: d.kind = x86mpp_pkg::K_BAD;
      endcase
    end
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_item = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= d;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push || q_pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
endmodule

### src/x86mpp_back.sv
// back end: register file, address generation, memory access, result register
// depends on x86mpp_pkg and x86mpp_ram
module x86mpp_back #(
  parameter int MEM_ADDR_BITS = x86mpp_pkg::MEM_ADDR_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic q_valid,
  output logic q_pop,
  input x86mpp_pkg::dec_t q_item,
  output logic res_valid,
  input logic res_ready,
  output x86mpp_pkg::res_t res
);
  localparam int AW = MEM_ADDR_BITS;

  logic [15:0] gr [8];
  logic [15:0] sr [4];
  logic halted;

  // phase 0 issues reads, phase 1 writes back and produces the result
  logic phase;
  logic [19:0] pa_r;
  x86mpp_pkg::dec_t it;
  logic [19:0] pa;
  logic [15:0] off;
  logic [1:0] seg;
  logic [15:0] d8x;
  logic uses_mem;
  logic [7:0] lo_rd;
  logic [7:0] hi_rd;
  logic [15:0] mrd;
  logic [19:0] pa_hi;
  logic [19:0] sp_pa;
  logic [15:0] sp_dec;

  assign it = q_item;

  // effective address
  always_comb begin
    seg = x86mpp_pkg::S_DS;
    unique case (it.rm)
      3'd0: off = gr[x86mpp_pkg::R_BX] + gr[x86mpp_pkg::R_SI];
      3'd1: off = gr[x86mpp_pkg::R_BX] + gr[x86mpp_pkg::R_DI];
      3'd2: begin
        off = gr[x86mpp_pkg::R_BP] + gr[x86mpp_pkg::R_SI];
        seg = x86mpp_pkg::S_SS;
      end
      3'd3: begin
        off = gr[x86mpp_pkg::R_BP] + gr[x86mpp_pkg::R_DI];
        seg = x86mpp_pkg::S_SS;
      end
      3'd4: off = gr[x86mpp_pkg::R_SI];
      3'd5: off = gr[x86mpp_pkg::R_DI];
      3'd6: begin
        if (it.md == 2'd0) off = it.disp;
        else begin
          off = gr[x86mpp_pkg::R_BP];
          seg = x86mpp_pkg::S_SS;
        end
      end
      default: off = gr[x86mpp_pkg::R_BX];
    endcase
    d8x = {{8{it.disp[7]}}, it.disp[7:0]};
    if (it.md == 2'd1) off = off + d8x;
    else if (it.md == 2'd2) off = off + it.disp;
  end

  assign sp_dec = gr[x86mpp_pkg::R_SP] - 16'd2;

  // physical address of the operand or stack slot
  always_comb begin
    uses_mem = 1'b0;
    sp_pa = {sr[x86mpp_pkg::S_SS], 4'd0} + {4'd0, gr[x86mpp_pkg::R_SP]};
    pa = 20'd0;
    case (it.kind)
      x86mpp_pkg::K_PUSH: begin
        pa = {sr[x86mpp_pkg::S_SS], 4'd0} + {4'd0, sp_dec};
        uses_mem = 1'b1;
      end
      x86mpp_pkg::K_POP: begin
        pa = sp_pa;
        uses_mem = 1'b1;
      end
      x86mpp_pkg::K_88, x86mpp_pkg::K_89, x86mpp_pkg::K_8A, x86mpp_pkg::K_8B,
      x86mpp_pkg::K_8C, x86mpp_pkg::K_8E, x86mpp_pkg::K_C6, x86mpp_pkg::K_C7: begin
        if (it.md != 2'd3) begin
          pa = {sr[seg], 4'd0} + {4'd0, off};
          uses_mem = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pa_hi = pa_r + 20'd1;

  // two copies of the byte memory so both bytes of a word are read together
  logic we;
  logic [AW-1:0] wa;
  logic [7:0] wd;
  logic [19:0] pa_rd_hi;

  assign pa_rd_hi = pa + 20'd1;

  x86mpp_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram_lo (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd),
    .raddr(pa[AW-1:0]), .rdata(lo_rd)
  );
  x86mpp_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram_hi (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd),
    .raddr(pa_rd_hi[AW-1:0]), .rdata(hi_rd)
  );

  assign mrd = {hi_rd, lo_rd};

  // execute in phase 1
  x86mpp_pkg::res_t r;
  logic [15:0] src16;
  logic [7:0] src8;
  logic gw16;
  logic gw8;
  logic sw;
  logic [2:0] wn;
  logic [15:0] wv;
  logic mw;
  logic mwide;
  logic [15:0] mv;
  logic sp_inc;
  logic sp_dec_en;
  logic go;
  logic [7:0] rg8;
  logic [7:0] rm8;

  // byte registers named by the reg and rm fields
  assign rg8 = it.rg[2] ? gr[{1'b0, it.rg[1:0]}][15:8] : gr[{1'b0, it.rg[1:0]}][7:0];
  assign rm8 = it.rm[2] ? gr[{1'b0, it.rm[1:0]}][15:8] : gr[{1'b0, it.rm[1:0]}][7:0];

  always_comb begin
    r = '0;
    gw16 = 1'b0;
    gw8 = 1'b0;
    sw = 1'b0;
    wn = 3'd0;
    wv = 16'd0;
    mw = 1'b0;
    mwide = 1'b0;
    mv = 16'd0;
    sp_inc = 1'b0;
    sp_dec_en = 1'b0;
    src16 = 16'd0;
    src8 = 8'd0;
    if (halted) r.status = x86mpp_pkg::ST_HALTED;
    else begin
      case (it.kind)
        x86mpp_pkg::K_IMM8: begin
          gw8 = 1'b1; wn = it.opreg; src8 = it.imm[7:0];
        end
        x86mpp_pkg::K_IMM16: begin
          gw16 = 1'b1; wn = it.opreg; src16 = it.imm;
        end
        x86mpp_pkg::K_PUSH: begin
          mw = 1'b1; mwide = 1'b1; mv = gr[it.opreg]; sp_dec_en = 1'b1;
        end
        x86mpp_pkg::K_POP: begin
          gw16 = 1'b1; wn = it.opreg; src16 = mrd; sp_inc = 1'b1;
        end
        x86mpp_pkg::K_88: begin
          src8 = rg8;
          if (it.md == 2'd3) begin gw8 = 1'b1; wn = it.rm; end
          else begin mw = 1'b1; mv = {8'd0, src8}; end
        end
        x86mpp_pkg::K_89: begin
          src16 = gr[it.rg];
          if (it.md == 2'd3) begin gw16 = 1'b1; wn = it.rm; end
          else begin mw = 1'b1; mwide = 1'b1; mv = src16; end
        end
        x86mpp_pkg::K_8A: begin
          gw8 = 1'b1; wn = it.rg;
          src8 = (it.md == 2'd3) ? rm8 : mrd[7:0];
        end
        x86mpp_pkg::K_8B: begin
          gw16 = 1'b1; wn = it.rg;
          src16 = (it.md == 2'd3) ? gr[it.rm] : mrd;
        end
        x86mpp_pkg::K_8C: begin
          src16 = sr[it.rg[1:0]];
          if (it.md == 2'd3) begin gw16 = 1'b1; wn = it.rm; end
          else begin mw = 1'b1; mwide = 1'b1; mv = src16; end
        end
        x86mpp_pkg::K_8E: begin
          sw = 1'b1; wn = {1'b0, it.rg[1:0]};
          src16 = (it.md == 2'd3) ? gr[it.rm] : mrd;
        end
        x86mpp_pkg::K_C6: begin
          src8 = it.imm[7:0];
          if (it.md == 2'd3) begin gw8 = 1'b1; wn = it.rm; end
          else begin mw = 1'b1; mv = {8'd0, src8}; end
        end
        x86mpp_pkg::K_C7: begin
          src16 = it.imm;
          if (it.md == 2'd3) begin gw16 = 1'b1; wn = it.rm; end
          else begin mw = 1'b1; mwide = 1'b1; mv = src16; end
        end
        default: r.status = x86mpp_pkg::ST_UNKNOWN;
      endcase
      // register value reads as zero when no register is written
      wv = gw8 ? {8'd0, src8} : ((gw16 || sw) ? src16 : 16'd0);
      r.mem_written = mw;
      r.mem_value = mv;
      r.mem_wide = mwide;
      r.phys_address = uses_mem ? pa_r : 20'd0;
      r.reg_written = gw8 | gw16 | sw;
      r.reg_class = sw ? x86mpp_pkg::RC_SEG : (gw8 ? x86mpp_pkg::RC_GEN8 : x86mpp_pkg::RC_GEN16);
      r.reg_number = wn;
      r.reg_value = wv;
    end
  end

  // second byte of a wide store goes in the cycle after, through a side register
  logic hi_pend;
  logic [AW-1:0] hi_addr;
  logic [7:0] hi_data;

  // both rams see the same writes so either copy can be read at any address
  assign go = phase && (!res_valid || res_ready);
  assign we = (go && mw) || hi_pend;
  assign wa = hi_pend ? hi_addr : pa_r[AW-1:0];
  assign wd = hi_pend ? hi_data : mv[7:0];
  assign q_pop = go;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      res_valid <= 1'b0;
      halted <= 1'b0;
      hi_pend <= 1'b0;
      for (int i = 0; i < 8; i++) gr[i] <= 16'd0;
      for (int i = 0; i < 4; i++) sr[i] <= 16'd0;
    end else begin
      hi_pend <= go && mw && mwide;
      if (go) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (!phase) begin
        if (q_valid && !hi_pend) phase <= 1'b1;
      end else if (go) begin
        phase <= 1'b0;
        if (!halted && it.kind == x86mpp_pkg::K_BAD) halted <= 1'b1;
        if (sp_dec_en) gr[x86mpp_pkg::R_SP] <= sp_dec;
        // pop into sp keeps the popped word
        if (sp_inc && wn != x86mpp_pkg::R_SP)
          gr[x86mpp_pkg::R_SP] <= gr[x86mpp_pkg::R_SP] + 16'd2;
        if (gw16) gr[wn] <= src16;
        if (gw8) begin
          if (wn[2]) gr[{1'b0, wn[1:0]}][15:8] <= src8;
          else gr[{1'b0, wn[1:0]}][7:0] <= src8;
        end
        if (sw) sr[wn[1:0]] <= src16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!phase) pa_r <= pa;
    if (go) begin
      res <= r;
      hi_addr <= pa_hi[AW-1:0];
      hi_data <= mv[15:8];
    end
  end

  a_pop_in_phase1: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> phase) else $error("pop outside execute phase");
  a_result_after_go: assert property (@(posedge clk) disable iff (rst)
    go |=> res_valid) else $error("result missing after execute");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halted) |-> halted) else $error("halted cleared");
endmodule

### src/x86_16bit_mov_push_pop_unit_core.sv
// top level of the 8086 mov/push/pop unit
// depends on x86mpp_pkg, x86mpp_front, x86mpp_back
// each instruction takes a read phase, then a write-back phase on the byte memory ram;
//   a 16-bit store also writes its second byte before the back end starts another instruction,
//   and the back end waits while a finished result is held back by m_tready
// reset: synchronous, clears registers, halted flag and queue; memory is not cleared
module x86_16bit_mov_push_pop_unit_core #(
  parameter int MEM_ADDR_BITS = x86mpp_pkg::MEM_ADDR_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  output logic s_tready,
  // opcode[7:0], modrm[15:8], displacement[31:16], immediate[47:32]
  input logic [47:0] s_tdata,
  output logic m_tvalid,
  input logic m_tready,
  // status[1:0], mem_written[2], phys_address[22:3], mem_value[38:23], mem_wide[39],
  // reg_written[40], reg_class[42:41], reg_number[45:43], reg_value[61:46]
  output logic [63:0] m_tdata
);
  logic q_valid;
  logic q_pop;
  x86mpp_pkg::dec_t q_item;
  x86mpp_pkg::res_t r;

  x86mpp_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .opcode(s_tdata[7:0]), .modrm(s_tdata[15:8]),
    .displacement(s_tdata[31:16]), .immediate(s_tdata[47:32]),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  x86mpp_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(r)
  );

  assign m_tdata = {2'd0, r.reg_value, r.reg_number, r.reg_class, r.reg_written,
                    r.mem_wide, r.mem_value, r.phys_address, r.mem_written, r.status};
endmodule

### bench/x86mpp_checker.sv
`timescale 1ns / 1ps
// checker for the 8086 mov/push/pop unit: watches both stream channels,
// predicts every result and compares it; depends on x86mpp_pkg
module x86mpp_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [47:0] s_tdata,
  input logic m_tvalid,
  input logic m_tready,
  input logic [63:0] m_tdata,
  output int failures,
  output int pending
);

  // shadow machine state
  logic [15:0] gpr [8];
  logic [15:0] sreg [4];
  logic [7:0] mem [65536];
  bit mem_ok [65536];
  bit halted;
  int accepted;
  x86mpp_pkg::res_t cur;
  x86mpp_pkg::res_t expected_q [$];

  function automatic logic [7:0] get8(input logic [2:0] n);
    return n[2] ? gpr[{1'b0, n[1:0]}][15:8] : gpr[{1'b0, n[1:0]}][7:0];
  endfunction

  function automatic void note(input logic [1:0] cls, input logic [2:0] n,
                               input logic [15:0] v);
    cur.reg_written = 1'b1;
    cur.reg_class = cls;
    cur.reg_number = n;
    cur.reg_value = v;
  endfunction

  function automatic void put8(input logic [2:0] n, input logic [7:0] v);
    if (n[2]) gpr[{1'b0, n[1:0]}][15:8] = v;
    else gpr[{1'b0, n[1:0]}][7:0] = v;
    note(x86mpp_pkg::RC_GEN8, n, {8'h00, v});
  endfunction

  function automatic void put16(input logic [2:0] n, input logic [15:0] v);
    gpr[n] = v;
    note(x86mpp_pkg::RC_GEN16, n, v);
  endfunction

  function automatic void store(input logic [19:0] p, input logic [15:0] v, input bit wide);
    mem[p[15:0]] = v[7:0];
    mem_ok[p[15:0]] = 1'b1;
    if (wide) begin
      mem[p[15:0] + 16'd1] = v[15:8];
      mem_ok[p[15:0] + 16'd1] = 1'b1;
    end
    cur.mem_written = 1'b1;
    cur.phys_address = p;
    cur.mem_value = wide ? v : {8'h00, v[7:0]};
    cur.mem_wide = wide;
  endfunction

  function automatic logic [15:0] load16(input logic [19:0] p);
    return {mem[p[15:0] + 16'd1], mem[p[15:0]]};
  endfunction

  function automatic logic [19:0] phys(input logic [15:0] seg, input logic [15:0] off);
    return {seg, 4'h0} + {4'h0, off};
  endfunction

  // modrm effective address; bp based modes go through ss
  function automatic logic [19:0] eff_addr(input logic [1:0] md, input logic [2:0] rm,
                                           input logic [15:0] disp);
    logic [15:0] off;
    logic [1:0] s;
    s = x86mpp_pkg::S_DS;
    case (rm)
      3'd0: off = gpr[x86mpp_pkg::R_BX] + gpr[x86mpp_pkg::R_SI];
      3'd1: off = gpr[x86mpp_pkg::R_BX] + gpr[x86mpp_pkg::R_DI];
      3'd2: begin
        off = gpr[x86mpp_pkg::R_BP] + gpr[x86mpp_pkg::R_SI];
        s = x86mpp_pkg::S_SS;
      end
      3'd3: begin
        off = gpr[x86mpp_pkg::R_BP] + gpr[x86mpp_pkg::R_DI];
        s = x86mpp_pkg::S_SS;
      end
      3'd4: off = gpr[x86mpp_pkg::R_SI];
      3'd5: off = gpr[x86mpp_pkg::R_DI];
      3'd6: begin
        if (md == 2'd0) off = disp;
        else begin off = gpr[x86mpp_pkg::R_BP]; s = x86mpp_pkg::S_SS; end
      end
      default: off = gpr[x86mpp_pkg::R_BX];
    endcase
    if (md == 2'd1) off = off + {{8{disp[7]}}, disp[7:0]};
    else if (md == 2'd2) off = off + disp;
    return phys(sreg[s], off);
  endfunction

  // true when the instruction reads only memory bytes already stored
  function automatic bit read_ok(input logic [47:0] d);
    logic [7:0] op;
    logic [19:0] p;
    op = d[7:0];
    if (halted) return 1'b1;
    if ((op & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_POP) begin
      p = phys(sreg[x86mpp_pkg::S_SS], gpr[x86mpp_pkg::R_SP]);
      return mem_ok[p[15:0]] && mem_ok[p[15:0] + 16'd1];
    end
    if (d[15:14] == 2'd3) return 1'b1;
    p = eff_addr(d[15:14], d[10:8], d[31:16]);
    if (op == x86mpp_pkg::OP_MOV_R8_RM8) return mem_ok[p[15:0]];
    if (op == x86mpp_pkg::OP_MOV_R16_RM16 || op == x86mpp_pkg::OP_MOV_SREG_RM16)
      return mem_ok[p[15:0]] && mem_ok[p[15:0] + 16'd1];
    return 1'b1;
  endfunction

  // run one instruction on the shadow state
  function automatic x86mpp_pkg::res_t execute(input logic [47:0] d);
    logic [7:0] op;
    logic [1:0] md;
    logic [2:0] rg, rm;
    logic [15:0] disp, imm, v, sp;
    logic [19:0] p;
    bit isreg;
    op = d[7:0];
    md = d[15:14];
    rg = d[13:11];
    rm = d[10:8];
    disp = d[31:16];
    imm = d[47:32];
    isreg = (md == 2'd3);
    cur = '0;
    p = '0;
    if (halted) begin
      cur.status = x86mpp_pkg::ST_HALTED;
    end else if ((op & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_MOV_R8_IMM) begin
      put8(op[2:0], imm[7:0]);
    end else if ((op & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_MOV_R16_IMM) begin
      put16(op[2:0], imm);
    end else if ((op & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_PUSH) begin
      v = gpr[op[2:0]];
      sp = gpr[x86mpp_pkg::R_SP] - 16'd2;
      gpr[x86mpp_pkg::R_SP] = sp;
      store(phys(sreg[x86mpp_pkg::S_SS], sp), v, 1'b1);
    end else if ((op & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_POP) begin
      sp = gpr[x86mpp_pkg::R_SP];
      p = phys(sreg[x86mpp_pkg::S_SS], sp);
      v = load16(p);
      cur.phys_address = p;
      gpr[x86mpp_pkg::R_SP] = sp + 16'd2;
      put16(op[2:0], v);
    end else if (op == x86mpp_pkg::OP_MOV_RM8_R8 || op == x86mpp_pkg::OP_MOV_RM16_R16 ||
                 op == x86mpp_pkg::OP_MOV_R8_RM8 || op == x86mpp_pkg::OP_MOV_R16_RM16 ||
                 op == x86mpp_pkg::OP_MOV_RM16_SREG || op == x86mpp_pkg::OP_MOV_SREG_RM16 ||
                 op == x86mpp_pkg::OP_MOV_RM8_IMM || op == x86mpp_pkg::OP_MOV_RM16_IMM) begin
      if (!isreg) begin
        p = eff_addr(md, rm, disp);
        cur.phys_address = p;
      end
      case (op)
        x86mpp_pkg::OP_MOV_RM8_R8:
          if (isreg) put8(rm, get8(rg)); else store(p, {8'h00, get8(rg)}, 1'b0);
        x86mpp_pkg::OP_MOV_RM16_R16:
          if (isreg) put16(rm, gpr[rg]); else store(p, gpr[rg], 1'b1);
        x86mpp_pkg::OP_MOV_R8_RM8:
          put8(rg, isreg ? get8(rm) : mem[p[15:0]]);
        x86mpp_pkg::OP_MOV_R16_RM16:
          put16(rg, isreg ? gpr[rm] : load16(p));
        x86mpp_pkg::OP_MOV_RM16_SREG:
          if (isreg) put16(rm, sreg[rg[1:0]]); else store(p, sreg[rg[1:0]], 1'b1);
        x86mpp_pkg::OP_MOV_SREG_RM16: begin
          v = isreg ? gpr[rm] : load16(p);
          sreg[rg[1:0]] = v;
          note(x86mpp_pkg::RC_SEG, {1'b0, rg[1:0]}, v);
        end
        x86mpp_pkg::OP_MOV_RM8_IMM:
          if (isreg) put8(rm, imm[7:0]); else store(p, {8'h00, imm[7:0]}, 1'b0);
        default:
          if (isreg) put16(rm, imm); else store(p, imm, 1'b1);
      endcase
    end else begin
      halted = 1'b1;
      cur.status = x86mpp_pkg::ST_UNKNOWN;
    end
    return cur;
  endfunction

  // predict on each request, compare on each result
  always @(posedge clk) begin
    x86mpp_pkg::res_t got;
    x86mpp_pkg::res_t want;
    if (rst) begin
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      for (int i = 0; i < 4; i++) sreg[i] = '0;
      halted = 1'b0;
      expected_q.delete();
      failures = 0;
      accepted = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(execute(s_tdata));
        accepted++;
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.mem_written = m_tdata[2];
        got.phys_address = m_tdata[22:3];
        got.mem_value = m_tdata[38:23];
        got.mem_wide = m_tdata[39];
        got.reg_written = m_tdata[40];
        got.reg_class = m_tdata[42:41];
        got.reg_number = m_tdata[45:43];
        got.reg_value = m_tdata[61:46];
        if (expected_q.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.mem_written !== want.mem_written ||
              got.phys_address !== want.phys_address || got.mem_value !== want.mem_value ||
              got.mem_wide !== want.mem_wide || got.reg_written !== want.reg_written ||
              got.reg_class !== want.reg_class || got.reg_number !== want.reg_number ||
              got.reg_value !== want.reg_value) begin
            failures++;
            if (failures <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  exp st=%0d mw=%0d pa=%h mv=%h wide=%0d rw=%0d rc=%0d rn=%0d rv=%h",
                       want.status, want.mem_written, want.phys_address, want.mem_value,
                       want.mem_wide, want.reg_written, want.reg_class, want.reg_number,
                       want.reg_value);
              $display("  got st=%0d mw=%0d pa=%h mv=%h wide=%0d rw=%0d rc=%0d rn=%0d rv=%h",
                       got.status, got.mem_written, got.phys_address, got.mem_value,
                       got.mem_wide, got.reg_written, got.reg_class, got.reg_number,
                       got.reg_value);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// top of the bench for the 8086 mov/push/pop unit: clock, reset, requests,
// result back pressure and verdict; depends on x86mpp_pkg and x86mpp_checker
module testbench;

  localparam int RANDOM_ITEMS = 1420;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [63:0] m_tdata;
  int failures;
  int pending;
  int sent;
  bit calm;
  logic [23:0] spots [$];

  x86_16bit_mov_push_pop_unit_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  x86mpp_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("x86_16bit_mov_push_pop_unit_core: mismatch");
    $finish;
  end

  function automatic logic [47:0] instr(input logic [7:0] op, input logic [7:0] mrm,
                                        input logic [15:0] disp, input logic [15:0] imm);
    return {imm, disp, mrm, op};
  endfunction

  // turn a read of never-stored memory into a store at the same place, or a pop into a push
  function automatic logic [47:0] make_safe(input logic [47:0] d);
    if (chk.read_ok(d)) return d;
    if ((d[7:0] & x86mpp_pkg::OP_GROUP_MASK) == x86mpp_pkg::OP_POP)
      return {d[47:8], x86mpp_pkg::OP_PUSH | {5'd0, d[2:0]}};
    return {d[47:8], x86mpp_pkg::OP_MOV_RM16_IMM};
  endfunction

  // register immediates, stack traffic, stores, loads of recently stored spots, register moves
  function automatic logic [47:0] random_instr();
    logic [7:0] op, mrm;
    logic [15:0] disp, imm;
    logic [23:0] spot;
    int r;
    disp = 16'($urandom);
    imm = 16'($urandom);
    mrm = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 12) begin
      op = x86mpp_pkg::OP_MOV_R8_IMM | 8'($urandom_range(0, 7));
    end else if (r < 24) begin
      op = x86mpp_pkg::OP_MOV_R16_IMM | 8'($urandom_range(0, 7));
    end else if (r < 34) begin
      op = x86mpp_pkg::OP_PUSH | 8'($urandom_range(0, 7));
    end else if (r < 42) begin
      op = x86mpp_pkg::OP_POP | 8'($urandom_range(0, 7));
    end else if (r < 62 || spots.size() == 0) begin
      case ($urandom_range(0, 4))
        0: op = x86mpp_pkg::OP_MOV_RM8_R8;
        1: op = x86mpp_pkg::OP_MOV_RM16_R16;
        2: op = x86mpp_pkg::OP_MOV_RM16_SREG;
        3: op = x86mpp_pkg::OP_MOV_RM8_IMM;
        default: op = x86mpp_pkg::OP_MOV_RM16_IMM;
      endcase
      if (mrm[7:6] == 2'd3) mrm[7:6] = 2'($urandom_range(0, 2));
      spots.push_back({disp, mrm});
      if (spots.size() > 8) void'(spots.pop_front());
    end else if (r < 84) begin
      case ($urandom_range(0, 2))
        0: op = x86mpp_pkg::OP_MOV_R8_RM8;
        1: op = x86mpp_pkg::OP_MOV_R16_RM16;
        default: op = x86mpp_pkg::OP_MOV_SREG_RM16;
      endcase
      spot = spots[$urandom_range(0, spots.size() - 1)];
      disp = spot[23:8];
      mrm = {spot[7:6], mrm[5:3], spot[2:0]};
    end else begin
      case ($urandom_range(0, 7))
        0: op = x86mpp_pkg::OP_MOV_RM8_R8;
        1: op = x86mpp_pkg::OP_MOV_RM16_R16;
        2: op = x86mpp_pkg::OP_MOV_R8_RM8;
        3: op = x86mpp_pkg::OP_MOV_R16_RM16;
        4: op = x86mpp_pkg::OP_MOV_RM16_SREG;
        5: op = x86mpp_pkg::OP_MOV_SREG_RM16;
        6: op = x86mpp_pkg::OP_MOV_RM8_IMM;
        default: op = x86mpp_pkg::OP_MOV_RM16_IMM;
      endcase
      mrm[7:6] = 2'd3;
    end
    return instr(op, mrm, disp, imm);
  endfunction

  // one request at a rising edge, with an optional idle burst before it;
  // the shadow state must include every accepted request before the next is fixed
  task automatic send(input logic [47:0] d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    wait (chk.accepted == sent);
    s_tdata <= make_safe(d);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // result side: random stalls, one long hold-off, none near the end
  initial begin
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    while (!calm) begin
      if (!held && sent >= 400) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    m_tready <= 1'b1;
  end

  // request side and verdict
  initial begin
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent = 0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: every operation, field extremes, stack wrap, aliases
    send(instr(x86mpp_pkg::OP_MOV_R8_IMM, 8'h00, 16'h0000, 16'hFFFF));
    send(instr(x86mpp_pkg::OP_MOV_R8_IMM | 8'd7, 8'hFF, 16'hFFFF, 16'h00A5));
    send(instr(x86mpp_pkg::OP_MOV_R16_IMM | 8'd7, 8'h00, 16'h0000, 16'hFFFF));
    send(instr(x86mpp_pkg::OP_MOV_R16_IMM | 8'd3, 8'h00, 16'h0000, 16'h1000));
    send(instr(x86mpp_pkg::OP_MOV_R16_IMM | 8'd6, 8'h00, 16'h0000, 16'h0010));
    send(instr(x86mpp_pkg::OP_MOV_RM16_IMM, 8'h06, 16'hFFFF, 16'h1234));
    send(instr(x86mpp_pkg::OP_MOV_R16_RM16, 8'h06, 16'hFFFF, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_SREG_RM16, 8'hD3, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_PUSH, 8'h00, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_POP | 8'd4, 8'h00, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM16_SREG, 8'h72, 16'h0080, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM16_SREG, 8'hF8, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM16_R16, 8'hBF, 16'h8000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_R16_RM16, 8'h8F, 16'h8000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM8_R8, 8'hE0, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM8_IMM, 8'h40, 16'h007F, 16'h00C3));
    send(instr(x86mpp_pkg::OP_MOV_R8_RM8, 8'h78, 16'h007F, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM8_R8, 8'h20, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_R8_RM8, 8'hC8, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_SREG_RM16, 8'hE6, 16'h0000, 16'h0000));
    send(instr(x86mpp_pkg::OP_MOV_RM16_IMM, 8'hC1, 16'h0000, 16'h8001));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 150) calm = 1'b1;
      send(random_instr());
    end

    // unknown opcode halts the unit; later requests are answered with halted status
    send(instr(8'h0F, 8'h00, 16'h0000, 16'h0000));
    for (int i = 0; i < 8; i++) send(instr(8'($urandom), 8'($urandom), 16'($urandom),
                                           16'($urandom)));
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("x86_16bit_mov_push_pop_unit_core: match");
    end else begin
      $display("x86_16bit_mov_push_pop_unit_core: mismatch");
    end
    $finish;
  end

endmodule
